[rtl/core/ascm_pkg.sv]
// Shared types and constants for the allocator size class mapper.
// Holds the class-size ROM, the beat structs and the inter-stage payloads.
// No dependencies.
`default_nettype none

package ascm_pkg;

    localparam int MAX_CLASS_BYTES  = 262144;
    localparam int FINE_RANGE_LIMIT = 1024;
    localparam int CLASS_COUNT      = 85;
    localparam int PAGE_BYTES       = 4096;
    localparam int MIN_ALIGN        = 8;
    localparam int COARSE_STEP      = 128;

    localparam int SIZE_W  = 32;
    localparam int ALIGN_W = 17;
    localparam int CLASS_W = 7;
    // The largest class is a multiple of the coarse step, so a rounded size
    // that passed the range check never exceeds it.
    localparam int NEED_W  = $clog2(MAX_CLASS_BYTES + 1);
    localparam int MASK_W  = $clog2(PAGE_BYTES);

    typedef logic [NEED_W-1:0] need_t;

    localparam need_t CLASS_BYTES [CLASS_COUNT] = '{
        19'd0,      19'd8,      19'd16,     19'd32,     19'd64,
        19'd80,     19'd96,     19'd112,    19'd128,    19'd144,
        19'd160,    19'd176,    19'd192,    19'd208,    19'd224,
        19'd240,    19'd256,    19'd272,    19'd288,    19'd304,
        19'd320,    19'd336,    19'd352,    19'd368,    19'd384,
        19'd400,    19'd416,    19'd448,    19'd480,    19'd512,
        19'd576,    19'd640,    19'd704,    19'd768,    19'd896,
        19'd1024,   19'd1152,   19'd1280,   19'd1408,   19'd1536,
        19'd1792,   19'd2048,   19'd2304,   19'd2688,   19'd2816,
        19'd3200,   19'd3456,   19'd3584,   19'd4096,   19'd4736,
        19'd5376,   19'd6144,   19'd6528,   19'd7168,   19'd8192,
        19'd9472,   19'd10240,  19'd12288,  19'd13568,  19'd14336,
        19'd16384,  19'd20480,  19'd24576,  19'd28672,  19'd32768,
        19'd40960,  19'd49152,  19'd57344,  19'd65536,  19'd73728,
        19'd81920,  19'd90112,  19'd98304,  19'd106496, 19'd114688,
        19'd131072, 19'd139264, 19'd147456, 19'd155648, 19'd172032,
        19'd188416, 19'd204800, 19'd221184, 19'd237568, 19'd262144
    };

    typedef struct packed {
        logic [SIZE_W-1:0]  request_size;
        logic [ALIGN_W-1:0] alignment;
    } req_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_idx;
        logic               error;
    } rsp_t;

    // Payload after range check and rounding.
    typedef struct packed {
        logic              err;
        need_t             need;
        logic [MASK_W-1:0] mask;
    } prep_t;

    // Payload after the parallel class compare; bit c says class c qualifies.
    typedef struct packed {
        logic                   err;
        logic [CLASS_COUNT-1:0] hits;
    } hit_t;

endpackage

`default_nettype wire

[rtl/core/ascm_prep.sv]
// First pipeline stage: range checks, alignment mask and request rounding.
// Depends on ascm_pkg.
`default_nettype none

module ascm_prep
    import ascm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_stall,
    input  wire req_t  up_data,
    output logic       down_valid,
    input  wire logic  down_stall,
    output prep_t      down_data
);

    logic  valid_reg;
    prep_t data_reg;
    prep_t data_next;
    logic  advance;

    logic [ALIGN_W-1:0] align_eff;
    logic [ALIGN_W-1:0] align_mask;
    logic [NEED_W:0]    size_ext;
    logic [NEED_W:0]    fine_sum;
    logic [NEED_W:0]    coarse_sum;
    logic               big_size;

    always_comb
    begin
        align_eff  = (up_data.alignment == '0) ? ALIGN_W'(1) : up_data.alignment;
        align_mask = align_eff - ALIGN_W'(1);
        big_size   = up_data.request_size > SIZE_W'(MAX_CLASS_BYTES);
        // Only the low bits matter once the size has passed the range check.
        size_ext   = up_data.request_size[NEED_W:0];
        fine_sum   = (size_ext + (NEED_W+1)'(MIN_ALIGN - 1))
                     & ~(NEED_W+1)'(MIN_ALIGN - 1);
        coarse_sum = (size_ext + (NEED_W+1)'(COARSE_STEP - 1))
                     & ~(NEED_W+1)'(COARSE_STEP - 1);

        data_next.err  = big_size || (align_eff > ALIGN_W'(PAGE_BYTES));
        data_next.mask = align_mask[MASK_W-1:0];
        if (size_ext <= (NEED_W+1)'(FINE_RANGE_LIMIT))
        begin
            data_next.need = fine_sum[NEED_W-1:0];
        end
        else
        begin
            data_next.need = coarse_sum[NEED_W-1:0];
        end
    end

    assign advance    = !valid_reg || !down_stall;
    assign up_stall   = !advance;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ascm_match.sv]
// Second pipeline stage: compares the rounded size against every ROM class but
// class zero in parallel and applies the alignment test. Depends on ascm_pkg.
`default_nettype none

module ascm_match
    import ascm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  up_valid,
    output logic       up_stall,
    input  wire prep_t up_data,
    output logic       down_valid,
    input  wire logic  down_stall,
    output hit_t       down_data
);

    logic valid_reg;
    hit_t data_reg;
    hit_t data_next;
    logic advance;

    always_comb
    begin
        data_next.err  = up_data.err;
        data_next.hits = '0;
        // Class zero is the empty entry and never serves a request.
        for (int c = 1; c < CLASS_COUNT; c++)
        begin
            data_next.hits[c] = (CLASS_BYTES[c] >= up_data.need)
                && ((CLASS_BYTES[c][MASK_W-1:0] & up_data.mask) == '0);
        end
    end

    assign advance    = !valid_reg || !down_stall;
    assign up_stall   = !advance;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ascm_encode.sv]
// Third pipeline stage: priority encoder that picks the lowest qualifying
// class and forms the result beat. Depends on ascm_pkg.
`default_nettype none

module ascm_encode
    import ascm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    output logic      up_stall,
    input  wire hit_t up_data,
    output logic      down_valid,
    input  wire logic down_stall,
    output rsp_t      down_data
);

    logic               valid_reg;
    rsp_t               data_reg;
    rsp_t               data_next;
    logic               advance;
    logic [CLASS_W-1:0] found;

    always_comb
    begin
        found = '0;
        for (int c = CLASS_COUNT - 1; c >= 1; c--)
        begin
            if (up_data.hits[c])
            begin
                found = CLASS_W'(c);
            end
        end
        if (up_data.err || (found == '0))
        begin
            data_next.error     = 1'b1;
            data_next.class_idx = '0;
        end
        else
        begin
            data_next.error     = 1'b0;
            data_next.class_idx = found;
        end
    end

    assign advance    = !valid_reg || !down_stall;
    assign up_stall   = !advance;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/allocator_size_class_mapper.sv]
// Top level of the allocator size class mapper: three pipeline stages.
// Depends on ascm_pkg, ascm_prep, ascm_match and ascm_encode.
//
//   Channel | Beat  | Handshake            | Payload
//   --------+-------+----------------------+---------------------------------
//   req     | in    | req_valid, req_stall | request_size, alignment
//   rsp     | out   | rsp_valid, rsp_stall | class_idx, error
//
// A request beat passes through the three stage registers in order: range
// check and rounding, the parallel ROM compare, and the priority encoder,
// whose register is the output register. A new beat can be accepted every
// cycle unless a stall on rsp has backed up to req_stall.
// Reset clears only the stage valid bits.
// A stall on rsp fills empty stages first and then backs up to req_stall.
`default_nettype none

module allocator_size_class_mapper
    import ascm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    logic  prep_valid;
    logic  prep_stall;
    prep_t prep_data;
    logic  hit_valid;
    logic  hit_stall;
    hit_t  hit_data;

    ascm_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (req_valid),
        .up_stall   (req_stall),
        .up_data    (req),
        .down_valid (prep_valid),
        .down_stall (prep_stall),
        .down_data  (prep_data)
    );

    ascm_match u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (prep_valid),
        .up_stall   (prep_stall),
        .up_data    (prep_data),
        .down_valid (hit_valid),
        .down_stall (hit_stall),
        .down_data  (hit_data)
    );

    ascm_encode u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (hit_valid),
        .up_stall   (hit_stall),
        .up_data    (hit_data),
        .down_valid (rsp_valid),
        .down_stall (rsp_stall),
        .down_data  (rsp)
    );

    // A good result always names a real class, and an error never does.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.error |-> (rsp.class_idx != '0)
            && (rsp.class_idx < CLASS_W'(CLASS_COUNT)))
    else $error("result class out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error |-> rsp.class_idx == '0)
    else $error("error result carries a class");

    // A request flagged in the compare stage as oversized or over-aligned must come out as an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_stall && hit_data.err |=> rsp_valid && rsp.error)
    else $error("range error lost in encoder");

    // With every stage empty, the input side cannot be stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !prep_valid && !hit_valid && !rsp_valid |-> !req_stall)
    else $error("empty pipeline stalls requests");

endmodule

`default_nettype wire
